// ----- src/ggh_pkg.sv -----
// ----------------------------------------------------------------------------
// ggh_pkg: shared definitions for the go-to-goal heading controller
// Field widths, fixed-point constants, register indexes and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package ggh_pkg;

    // Field widths
    localparam int COORD_W   = 16;   // Q5.11 unsigned coordinates and speeds
    localparam int HEAD_W    = 16;   // Q3.13 signed angle
    localparam int RATE_W    = 15;   // Q2.13 unsigned magnitudes
    localparam int NUM_W     = 16;   // target number
    localparam int DELTA_W   = COORD_W + 1;  // signed offset
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // CORDIC datapath widths
    localparam int XY_W        = 32;
    localparam int Z_W         = 20;
    localparam int BEAR_W      = 17;
    localparam int ATAN_IDX_W  = 5;
    localparam int ATAN_ENTRIES = 20;

    // Shared multiplier widths
    localparam int MUL_W  = 29;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DSQ_W  = 33;

    // Angle constants
    localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [17:0]    PI_Q13      = 18'sd25736;
    localparam logic signed [17:0]    TWO_PI_Q13  = 18'sd51472;
    localparam logic [RATE_W-1:0]     PI_MAG_Q13  = 15'd25736;

    // Divide by 25736 = 8 * 3217: shift by 3, then reciprocal of 3217
    // m = ceil(2^40 / 3217), exact for every 28-bit dividend
    localparam logic [MUL_W-1:0] RECIP_3217 = 29'd341781669;
    localparam int               RECIP_SHIFT = 40;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CATCH_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_TOL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_COORD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_COORD    = 3'd5;

    // Register reset values
    localparam logic [COORD_W-1:0] RST_CATCH_RADIUS = 16'd1024;
    localparam logic [RATE_W-1:0]  RST_TURN_RATE    = 15'd12288;
    localparam logic [COORD_W-1:0] RST_CRUISE_SPEED = 16'd4096;
    localparam logic [RATE_W-1:0]  RST_HEADING_TOL  = 15'd819;
    localparam logic [COORD_W-1:0] RST_NEAR_COORD   = 16'd4096;
    localparam logic [COORD_W-1:0] RST_FAR_COORD    = 16'd18432;
    localparam logic [NUM_W-1:0]   RST_TARGET       = 16'd2;

    // CORDIC unit status toward the sequencer
    typedef struct packed {
        logic                     done;
        logic signed [BEAR_W-1:0] bearing;
    } cordic_res_t;

    // atan(2^-i) in Q.16, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        begin
            case (idx)
                5'd0:    val = 20'sd51472;
                5'd1:    val = 20'sd30385;
                5'd2:    val = 20'sd16055;
                5'd3:    val = 20'sd8150;
                5'd4:    val = 20'sd4091;
                5'd5:    val = 20'sd2047;
                5'd6:    val = 20'sd1024;
                5'd7:    val = 20'sd512;
                5'd8:    val = 20'sd256;
                5'd9:    val = 20'sd128;
                5'd10:   val = 20'sd64;
                5'd11:   val = 20'sd32;
                5'd12:   val = 20'sd16;
                5'd13:   val = 20'sd8;
                5'd14:   val = 20'sd4;
                5'd15:   val = 20'sd2;
                5'd16:   val = 20'sd1;
                default: val = 20'sd0;
            endcase
            return val;
        end
    endfunction

endpackage

// ----- src/ggh_mul.sv -----
// ----------------------------------------------------------------------------
// ggh_mul: shared unsigned multiplier
// One product per cycle, registered output; operands chosen by the sequencer.
// ----------------------------------------------------------------------------
module ggh_mul (
    input  logic                          clk,
    input  logic [ggh_pkg::MUL_W-1:0]     a,
    input  logic [ggh_pkg::MUL_W-1:0]     b,
    output logic [ggh_pkg::PROD_W-1:0]    prod
);

    logic [ggh_pkg::PROD_W-1:0] prod_reg;

    // Product register
    always_ff @(posedge clk)
    begin
        prod_reg <= ggh_pkg::PROD_W'(a) * ggh_pkg::PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ----- src/ggh_cordic.sv -----
// ----------------------------------------------------------------------------
// ggh_cordic: iterative CORDIC atan2
// Vectoring mode, one micro-rotation per cycle on a shared shift/add unit.
// Bearing is returned in Q3.13, rounded from the Q.16 angle accumulator.
// ----------------------------------------------------------------------------
module ggh_cordic #(
    parameter int CORDIC_STEPS = 14
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [ggh_pkg::DELTA_W-1:0]    dx,
    input  logic signed [ggh_pkg::DELTA_W-1:0]    dy,
    output ggh_pkg::cordic_res_t                  res
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam int XY_W  = ggh_pkg::XY_W;
    localparam int Z_W   = ggh_pkg::Z_W;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        it_reg, it_next;
    logic signed [XY_W-1:0]  x_reg, x_next;
    logic signed [XY_W-1:0]  y_reg, y_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic                    zero_reg, zero_next;

    logic signed [XY_W-1:0]  x_in, y_in;
    logic signed [XY_W-1:0]  xs, ys;
    logic signed [Z_W-1:0]   ang;
    logic signed [Z_W-1:0]   z_round;
    logic                    last_step;

    // Inputs scaled by 4096
    assign x_in = {{(XY_W-ggh_pkg::DELTA_W-12){dx[ggh_pkg::DELTA_W-1]}}, dx, 12'd0};
    assign y_in = {{(XY_W-ggh_pkg::DELTA_W-12){dy[ggh_pkg::DELTA_W-1]}}, dy, 12'd0};

    // Shared shift/add step
    assign xs        = x_reg >>> it_reg;
    assign ys        = y_reg >>> it_reg;
    assign ang       = ggh_pkg::atan_q16(ggh_pkg::ATAN_IDX_W'(it_reg));
    assign last_step = (it_reg == CNT_W'(CORDIC_STEPS - 1));

    // Sequencing of load, iterations and done
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        it_next   = it_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            it_next   = '0;
            zero_next = (dx == '0) && (dy == '0);
            // Pre-rotation into the right half plane
            if (dx[ggh_pkg::DELTA_W-1])
            begin
                if (!dy[ggh_pkg::DELTA_W-1])
                begin
                    x_next = y_in;
                    y_next = -x_in;
                    z_next = ggh_pkg::HALF_PI_Q16;
                end
                else
                begin
                    x_next = -y_in;
                    y_next = x_in;
                    z_next = -ggh_pkg::HALF_PI_Q16;
                end
            end
            else
            begin
                x_next = x_in;
                y_next = y_in;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[XY_W-1])
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                it_next = it_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    // Round Q.16 to Q3.13: floor((z + 4) / 8)
    assign z_round     = (z_reg + Z_W'(4)) >>> 3;
    assign res.done    = done_reg;
    assign res.bearing = zero_reg ? '0 : z_round[ggh_pkg::BEAR_W-1:0];

endmodule

// ----- src/go_to_goal_heading_controller_unit.sv -----
// ----------------------------------------------------------------------------
// go_to_goal_heading_controller_unit: turn-then-drive go-to-goal controller
// One pose in, one velocity command out; tracks the current target corner.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one pose request per transfer, tdata = {heading, y, x}.
//   Output stream m_*: one command per pose, tdata = {caught_number,
//   angular, linear}, tuser = caught flag.
//   cfg_we/cfg_addr/cfg_data write the six settings; write only while idle.
// Steps from accept to output valid (receiver ready):
//   catch:            S_SQX, S_SQY, S_SQR, S_CMP, then S_DONE
//   turn in place:    catch steps to S_CMP, then S_CORD, S_WRAP, S_DONE
//   drive:            turn steps to S_WRAP, then S_MUL1, S_MUL2, S_DONE
// Flow: a new pose is taken only after the last has left S_DONE, since
// s_tready is high only in idle. The CORDIC unit (one micro-rotation per
// cycle) sets most of a turn or drive; the shared multiplier handles the
// squared distance and radius and the speed scaling one product per cycle.
// Reset: settings return to their defaults, target number to 2, output empty.
// Stall: a finished command sits in the output register; the next pose is
// taken meanwhile and waits at its end until the register frees up.
// ----------------------------------------------------------------------------
module go_to_goal_heading_controller_unit #(
    parameter int CORDIC_STEPS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    // Pose input; tdata: pose_x[15:0], pose_y[31:16], pose_heading[47:32]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    // Command output; tdata: linear_velocity[15:0], angular_velocity[31:16],
    // caught_number[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // tuser: caught[0]
    output logic        m_tuser,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    localparam int COORD_W = ggh_pkg::COORD_W;
    localparam int RATE_W  = ggh_pkg::RATE_W;
    localparam int DELTA_W = ggh_pkg::DELTA_W;
    localparam int MUL_W   = ggh_pkg::MUL_W;
    localparam int PROD_W  = ggh_pkg::PROD_W;
    localparam int DSQ_W   = ggh_pkg::DSQ_W;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_SQX  = 10'b00_0000_0010,
        S_SQY  = 10'b00_0000_0100,
        S_SQR  = 10'b00_0000_1000,
        S_CMP  = 10'b00_0001_0000,
        S_CORD = 10'b00_0010_0000,
        S_WRAP = 10'b00_0100_0000,
        S_MUL1 = 10'b00_1000_0000,
        S_MUL2 = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Settings
    logic [COORD_W-1:0] radius_reg, cruise_reg, near_reg, far_reg;
    logic [RATE_W-1:0]  turn_reg, tol_reg;
    logic [ggh_pkg::NUM_W-1:0] target_reg, target_next;

    // Item registers
    logic signed [DELTA_W-1:0]        dx_reg, dy_reg;
    logic signed [ggh_pkg::HEAD_W-1:0] head_reg;
    logic [DSQ_W-1:0]                 dsq_reg, dsq_next;
    logic signed [17:0]               err_reg, err_next;
    logic [COORD_W-1:0]               res_lin_reg, res_lin_next;
    logic signed [15:0]               res_ang_reg, res_ang_next;
    logic                             res_caught_reg, res_caught_next;

    // Output register
    logic                       out_valid_reg, out_valid_next;
    logic [47:0]                out_data_reg;
    logic                       out_user_reg;
    logic                       out_load;

    // Shared units
    logic [MUL_W-1:0]           mul_a, mul_b;
    logic [PROD_W-1:0]          prod;
    logic                       cordic_start;
    ggh_pkg::cordic_res_t       cordic_res;

    logic                       accept;
    logic [COORD_W-1:0]         tx, ty;
    logic signed [DELTA_W-1:0]  dx_in, dy_in;
    logic [COORD_W-1:0]         abs_dx, abs_dy;
    logic signed [17:0]         err_raw, err_wrap;
    logic [RATE_W-1:0]          mag;
    logic [RATE_W-1:0]          mag_rest;

    ggh_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ggh_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .res   (cordic_res)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Target corner and offset
    assign tx    = target_reg[0] ? far_reg : near_reg;
    assign ty    = target_reg[1] ? far_reg : near_reg;
    assign dx_in = DELTA_W'(tx) - DELTA_W'(s_tdata[15:0]);
    assign dy_in = DELTA_W'(ty) - DELTA_W'(s_tdata[31:16]);
    assign abs_dx = dx_reg[DELTA_W-1] ? COORD_W'(-dx_reg) : COORD_W'(dx_reg);
    assign abs_dy = dy_reg[DELTA_W-1] ? COORD_W'(-dy_reg) : COORD_W'(dy_reg);

    // Heading error and wrap into [-pi, pi]
    assign err_raw = 18'(cordic_res.bearing) - 18'(head_reg);
    always_comb
    begin
        if (err_reg > ggh_pkg::PI_Q13)
            err_wrap = err_reg - ggh_pkg::TWO_PI_Q13;
        else if (err_reg < -ggh_pkg::PI_Q13)
            err_wrap = err_reg + ggh_pkg::TWO_PI_Q13;
        else
            err_wrap = err_reg;
    end
    assign mag      = err_wrap[17] ? RATE_W'(-err_wrap) : RATE_W'(err_wrap);
    assign mag_rest = ggh_pkg::PI_MAG_Q13 - mag;

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQX:
            begin
                mul_a = MUL_W'(abs_dx);
                mul_b = MUL_W'(abs_dx);
            end
            S_SQY:
            begin
                mul_a = MUL_W'(abs_dy);
                mul_b = MUL_W'(abs_dy);
            end
            S_SQR:
            begin
                mul_a = MUL_W'(radius_reg);
                mul_b = MUL_W'(radius_reg);
            end
            S_WRAP:
            begin
                mul_a = MUL_W'(cruise_reg);
                mul_b = MUL_W'(mag_rest);
            end
            S_MUL1:
            begin
                mul_a = MUL_W'(prod[30:3]);
                mul_b = ggh_pkg::RECIP_3217;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        dsq_next        = dsq_reg;
        err_next        = err_reg;
        res_lin_next    = res_lin_reg;
        res_ang_next    = res_ang_reg;
        res_caught_next = res_caught_reg;
        target_next     = target_reg;
        cordic_start    = 1'b0;
        out_load        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_SQX;
            end
            S_SQX:
                state_next = S_SQY;
            S_SQY:
            begin
                dsq_next   = DSQ_W'(prod[31:0]);
                state_next = S_SQR;
            end
            S_SQR:
            begin
                dsq_next   = dsq_reg + DSQ_W'(prod[31:0]);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // Catch test on squared distances
                if (dsq_reg < DSQ_W'(prod[31:0]))
                begin
                    res_lin_next    = '0;
                    res_ang_next    = '0;
                    res_caught_next = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    res_caught_next = 1'b0;
                    cordic_start    = 1'b1;
                    state_next      = S_CORD;
                end
            end
            S_CORD:
            begin
                if (cordic_res.done)
                begin
                    err_next   = err_raw;
                    state_next = S_WRAP;
                end
            end
            S_WRAP:
            begin
                res_ang_next = err_wrap[15:0];
                if (mag > tol_reg)
                begin
                    // Turn in place
                    res_lin_next = '0;
                    res_ang_next = err_wrap[17] ? -16'(turn_reg) : 16'(turn_reg);
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
                state_next = S_MUL2;
            S_MUL2:
            begin
                res_lin_next = prod[ggh_pkg::RECIP_SHIFT +: COORD_W];
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    if (res_caught_reg)
                        target_next = target_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Control state and settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            target_reg    <= ggh_pkg::RST_TARGET;
            radius_reg    <= ggh_pkg::RST_CATCH_RADIUS;
            turn_reg      <= ggh_pkg::RST_TURN_RATE;
            cruise_reg    <= ggh_pkg::RST_CRUISE_SPEED;
            tol_reg       <= ggh_pkg::RST_HEADING_TOL;
            near_reg      <= ggh_pkg::RST_NEAR_COORD;
            far_reg       <= ggh_pkg::RST_FAR_COORD;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            target_reg    <= target_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    ggh_pkg::CFG_CATCH_RADIUS: radius_reg <= cfg_data;
                    ggh_pkg::CFG_TURN_RATE:    turn_reg   <= cfg_data[RATE_W-1:0];
                    ggh_pkg::CFG_CRUISE_SPEED: cruise_reg <= cfg_data;
                    ggh_pkg::CFG_HEADING_TOL:  tol_reg    <= cfg_data[RATE_W-1:0];
                    ggh_pkg::CFG_NEAR_COORD:   near_reg   <= cfg_data;
                    ggh_pkg::CFG_FAR_COORD:    far_reg    <= cfg_data;
                    default:                   ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_reg   <= dx_in;
            dy_reg   <= dy_in;
            head_reg <= s_tdata[47:32];
        end
        dsq_reg        <= dsq_next;
        err_reg        <= err_next;
        res_lin_reg    <= res_lin_next;
        res_ang_reg    <= res_ang_next;
        res_caught_reg <= res_caught_next;
        if (out_load)
        begin
            out_data_reg[15:0]  <= res_lin_reg;
            out_data_reg[31:16] <= res_ang_reg;
            out_data_reg[47:32] <= res_caught_reg ? target_reg : '0;
            out_user_reg        <= res_caught_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- src/ggh_checker.sv -----
// ----------------------------------------------------------------------------
// ggh_checker: port-level checks for the go-to-goal controller
// Watches the streams only; bound onto the top level.
// ----------------------------------------------------------------------------
module ggh_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tuser
);

    // A taken pose keeps the input closed while it is worked on
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a request was taken");

    // A stalled command holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled command changed");

    // A catch commands zero velocity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
    else $error("catch with nonzero velocity");

    // The target number is shown only with a catch
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[47:32] == 16'd0)
    else $error("target number without a catch");

endmodule

bind go_to_goal_heading_controller_unit ggh_checker u_ggh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
